>>> rtl/ppcs_pkg.sv
// ----------------------------------------------------------------------------
// ppcs_pkg
// Shared types and codes of the pick-and-place cycle sequencer.
// ----------------------------------------------------------------------------
package ppcs_pkg;

  localparam int PHASE_W   = 3;
  localparam int POLL_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_CFG   = 8;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WORK    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_AWAIT   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LOWER   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

  localparam logic [POLL_W-1:0] POLL_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_WORK_X      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_Y      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_Z      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAB_Z_UP   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAB_Z_DOWN = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLACE_X     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLACE_Y     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLACE_Z     = 4'd7;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               busy;
    logic               grab_sent;
    logic [POLL_W-1:0]  poll_count;
  } ctrl_t;

endpackage

>>> rtl/ppcs_step.sv
// ----------------------------------------------------------------------------
// ppcs_step
// Next-state and command logic for one poll tick of the sequencer.
// ----------------------------------------------------------------------------
module ppcs_step #(
  parameter int COORD_WIDTH = 20,
  parameter int RETRY_LIMIT = 20
) (
  input  ppcs_pkg::ctrl_t                 ctrl_cur,
  input  logic signed [COORD_WIDTH-1:0]   saved_x_cur,
  input  logic signed [COORD_WIDTH-1:0]   saved_y_cur,
  input  logic signed [COORD_WIDTH-1:0]   cfg_regs [ppcs_pkg::NUM_CFG],
  input  logic                            start_req,
  input  logic                            stop_req,
  input  logic                            move_done,
  input  logic                            vacuum_ok,
  input  logic                            target_found,
  input  logic signed [COORD_WIDTH-1:0]   target_x,
  input  logic signed [COORD_WIDTH-1:0]   target_y,
  output ppcs_pkg::ctrl_t                 ctrl_nxt,
  output logic signed [COORD_WIDTH-1:0]   saved_x_nxt,
  output logic signed [COORD_WIDTH-1:0]   saved_y_nxt,
  output logic                            cmd_valid,
  output logic signed [COORD_WIDTH-1:0]   cmd_x,
  output logic signed [COORD_WIDTH-1:0]   cmd_y,
  output logic signed [COORD_WIDTH-1:0]   cmd_z,
  output logic                            cycle_end
);

  localparam logic [ppcs_pkg::POLL_W-1:0] RETRY_LIM = ppcs_pkg::POLL_W'(RETRY_LIMIT);

  logic busy_now;
  logic active;

  assign busy_now = ctrl_cur.busy & ~move_done;
  assign active   = (ctrl_cur.phase == ppcs_pkg::PH_WORK) ||
                    (ctrl_cur.phase == ppcs_pkg::PH_AWAIT) ||
                    (ctrl_cur.phase == ppcs_pkg::PH_LOWER) ||
                    (ctrl_cur.phase == ppcs_pkg::PH_RELEASE);

  always_comb begin
    ctrl_nxt      = ctrl_cur;
    ctrl_nxt.busy = busy_now;
    saved_x_nxt   = saved_x_cur;
    saved_y_nxt   = saved_y_cur;
    cmd_valid     = 1'b0;
    cmd_x         = '0;
    cmd_y         = '0;
    cmd_z         = '0;
    cycle_end     = 1'b0;

    if (active && stop_req && !busy_now) begin
      ctrl_nxt.phase = ppcs_pkg::PH_IDLE;
      cycle_end      = 1'b1;
    end else begin
      unique case (ctrl_cur.phase)
        ppcs_pkg::PH_WORK: begin
          if (!busy_now) begin
            ctrl_nxt.phase     = ppcs_pkg::PH_AWAIT;
            ctrl_nxt.grab_sent = 1'b0;
          end
        end
        ppcs_pkg::PH_AWAIT: begin
          if (target_found && !ctrl_cur.grab_sent) begin
            saved_x_nxt        = target_x;
            saved_y_nxt        = target_y;
            cmd_valid          = 1'b1;
            cmd_x              = target_x;
            cmd_y              = target_y;
            cmd_z              = cfg_regs[ppcs_pkg::REG_GRAB_Z_UP[2:0]];
            ctrl_nxt.busy      = 1'b1;
            ctrl_nxt.grab_sent = 1'b1;
          end else if (!busy_now && ctrl_cur.grab_sent) begin
            ctrl_nxt.phase      = ppcs_pkg::PH_LOWER;
            ctrl_nxt.poll_count = '0;
            cmd_valid           = 1'b1;
            cmd_x               = saved_x_cur;
            cmd_y               = saved_y_cur;
            cmd_z               = cfg_regs[ppcs_pkg::REG_GRAB_Z_DOWN[2:0]];
            ctrl_nxt.busy       = 1'b1;
          end
        end
        ppcs_pkg::PH_LOWER: begin
          if (ctrl_cur.poll_count > RETRY_LIM) begin
            ctrl_nxt.phase = ppcs_pkg::PH_WORK;
            cmd_valid      = 1'b1;
            cmd_x          = cfg_regs[ppcs_pkg::REG_WORK_X[2:0]];
            cmd_y          = cfg_regs[ppcs_pkg::REG_WORK_Y[2:0]];
            cmd_z          = cfg_regs[ppcs_pkg::REG_WORK_Z[2:0]];
            ctrl_nxt.busy  = 1'b1;
          end else begin
            if (!busy_now && vacuum_ok) begin
              ctrl_nxt.phase = ppcs_pkg::PH_RELEASE;
              cmd_valid      = 1'b1;
              cmd_x          = cfg_regs[ppcs_pkg::REG_PLACE_X[2:0]];
              cmd_y          = cfg_regs[ppcs_pkg::REG_PLACE_Y[2:0]];
              cmd_z          = cfg_regs[ppcs_pkg::REG_PLACE_Z[2:0]];
              ctrl_nxt.busy  = 1'b1;
            end
            if (ctrl_cur.poll_count != ppcs_pkg::POLL_MAX) begin
              ctrl_nxt.poll_count = ctrl_cur.poll_count + 1'b1;
            end
          end
        end
        ppcs_pkg::PH_RELEASE: begin
          if (!busy_now) begin
            ctrl_nxt.phase = ppcs_pkg::PH_WORK;
            cmd_valid      = 1'b1;
            cmd_x          = cfg_regs[ppcs_pkg::REG_WORK_X[2:0]];
            cmd_y          = cfg_regs[ppcs_pkg::REG_WORK_Y[2:0]];
            cmd_z          = cfg_regs[ppcs_pkg::REG_WORK_Z[2:0]];
            ctrl_nxt.busy  = 1'b1;
          end
        end
        default: begin
          ctrl_nxt.phase = ppcs_pkg::PH_IDLE;
          if (start_req) begin
            ctrl_nxt.phase = ppcs_pkg::PH_WORK;
            cmd_valid      = 1'b1;
            cmd_x          = cfg_regs[ppcs_pkg::REG_WORK_X[2:0]];
            cmd_y          = cfg_regs[ppcs_pkg::REG_WORK_Y[2:0]];
            cmd_z          = cfg_regs[ppcs_pkg::REG_WORK_Z[2:0]];
            ctrl_nxt.busy  = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/pick_place_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// pick_place_cycle_sequencer
// Pick-and-place cycle sequencer, one poll beat in, one command beat out.
// ----------------------------------------------------------------------------
// Every accepted input beat is one poll tick and yields exactly one result
// beat, which appears in the output register on the cycle after acceptance.
// A new beat is accepted every cycle while the result register is empty or
// being drained in the same cycle, so the sustained rate is one beat per
// clock; the single output register holds each result. The eight position
// registers are written through the cfg_ port, which is always ready.
module pick_place_cycle_sequencer #(
  parameter int COORD_WIDTH = 20,
  parameter int RETRY_LIMIT = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // start_req, stop_req, move_done, vacuum_ok, target_found, target_x, target_y
  input  logic [((5 + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cmd_valid, cmd_x, cmd_y, cmd_z, phase, cycle_end
  output logic [((5 + 3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ppcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int OUT_W     = 5 + 3 * COORD_WIDTH;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;
  localparam int PH_LSB    = 1 + 3 * COORD_WIDTH;
  localparam int END_BIT   = PH_LSB + ppcs_pkg::PHASE_W;

  ppcs_pkg::ctrl_t ctrl_r, ctrl_nxt;
  logic signed [COORD_WIDTH-1:0] saved_x_r, saved_x_nxt;
  logic signed [COORD_WIDTH-1:0] saved_y_r, saved_y_nxt;
  logic signed [COORD_WIDTH-1:0] cfg_r [ppcs_pkg::NUM_CFG];

  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;

  logic                          in_fire;
  logic                          cmd_valid, cycle_end;
  logic signed [COORD_WIDTH-1:0] cmd_x, cmd_y, cmd_z;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  ppcs_step #(
    .COORD_WIDTH (COORD_WIDTH),
    .RETRY_LIMIT (RETRY_LIMIT)
  ) u_step (
    .ctrl_cur     (ctrl_r),
    .saved_x_cur  (saved_x_r),
    .saved_y_cur  (saved_y_r),
    .cfg_regs     (cfg_r),
    .start_req    (in_tdata[0]),
    .stop_req     (in_tdata[1]),
    .move_done    (in_tdata[2]),
    .vacuum_ok    (in_tdata[3]),
    .target_found (in_tdata[4]),
    .target_x     (in_tdata[5 +: COORD_WIDTH]),
    .target_y     (in_tdata[5 + COORD_WIDTH +: COORD_WIDTH]),
    .ctrl_nxt     (ctrl_nxt),
    .saved_x_nxt  (saved_x_nxt),
    .saved_y_nxt  (saved_y_nxt),
    .cmd_valid    (cmd_valid),
    .cmd_x        (cmd_x),
    .cmd_y        (cmd_y),
    .cmd_z        (cmd_z),
    .cycle_end    (cycle_end)
  );

  assign out_data_nxt = {cycle_end, ctrl_nxt.phase, cmd_z, cmd_y, cmd_x, cmd_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      saved_x_r   <= '0;
      saved_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ctrl_r      <= ctrl_nxt;
        saved_x_r   <= saved_x_nxt;
        saved_y_r   <= saved_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ppcs_pkg::NUM_CFG; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < ppcs_pkg::CFG_IDX_W'(ppcs_pkg::NUM_CFG))) begin
      cfg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_BYTES*8-OUT_W){1'b0}}, out_data_r};

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted beat did not produce a result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while result stalled");

  a_end_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[END_BIT])
      |-> (out_tdata[PH_LSB +: ppcs_pkg::PHASE_W] == ppcs_pkg::PH_IDLE))
    else $error("cycle end reported outside idle");

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[1 +: 3 * COORD_WIDTH] == '0))
    else $error("coordinates nonzero without a command");

endmodule
